// File: hw/rtl/atm_pkg.sv
// ----------------------------------------------------------------------------
// atm_pkg
// Shared constants for the trimmed mean filter: batch geometry, code widths
// and the reciprocal used to divide each middle entry by half the batch size.
// ----------------------------------------------------------------------------
`default_nettype none

package atm_pkg;

  // Port widths of the converter code and of the average.
  localparam int CodeBits = 16;
  localparam int AvgBits  = 16;

  // Batch geometry.
  localparam int SampleCount  = 8;
  localparam int SampleBits   = 16;
  localparam int IdxW         = $clog2(SampleCount);
  localparam int QuarterCount = SampleCount >> 2;
  localparam int HalfCount    = SampleCount >> 1;

  // First and last store entry that take part in the sum.
  localparam logic [IdxW-1:0] SumFirst = IdxW'(QuarterCount);
  localparam logic [IdxW-1:0] SumLast  = IdxW'(SampleCount - QuarterCount - 1);
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(SampleCount - 1);

  // Division by HalfCount as a multiplication by a rounded-up reciprocal.
  // With DivShift = SampleBits + ceil(log2(HalfCount)) the quotient is exact
  // for every SampleBits-wide dividend.
  localparam int DivShift = SampleBits + $clog2(HalfCount);
  localparam int MulW     = SampleBits + 2;
  localparam int ProdW    = SampleBits + MulW;
  localparam longint unsigned DivMulWide =
      ((64'd1 << DivShift) + HalfCount - 1) / HalfCount;
  localparam logic [MulW-1:0] DivMul = MulW'(DivMulWide);

endpackage

`default_nettype wire

// File: hw/rtl/atm_ram.sv
// ----------------------------------------------------------------------------
// atm_ram
// Generic simple dual-port RAM: one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module atm_ram #(
  parameter int Width = 16,
  parameter int Depth = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hw/rtl/atm_div.sv
// ----------------------------------------------------------------------------
// atm_div
// Registered division of a stored code by half the batch size, done as a
// multiplication by a constant reciprocal.
// ----------------------------------------------------------------------------
`default_nettype none

module atm_div
  import atm_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  input  wire logic [SampleBits-1:0] dividend_i,
  output logic                       valid_o,
  output logic      [SampleBits-1:0] quotient_o
);

  logic [ProdW-1:0]      prod;
  logic [SampleBits-1:0] quot_d;
  logic [SampleBits-1:0] quot_q;
  logic                  valid_q;

  assign prod   = ProdW'(dividend_i) * ProdW'(DivMul);
  assign quot_d = SampleBits'(prod >> DivShift);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
  end

  assign valid_o    = valid_q;
  assign quotient_o = quot_q;

endmodule

`default_nettype wire

// File: hw/rtl/adc_trimmed_mean_top.sv
// ----------------------------------------------------------------------------
// adc_trimmed_mean_top
// Interquartile trimmed mean over batches of converter codes.
// ----------------------------------------------------------------------------
// Usage: a converter code is offered on sample_code_i with start high; the
// transaction is taken at the rising edge where start is high and busy is low.
// Every code is placed at once into its sorted position in the sample RAM by
// an insertion step: the entries above it are moved up one place per cycle,
// read and written back through the RAM's two ports.
// The first code of a batch is written straight in and leaves the block
// free. A code that lands at batch position k (from zero, k above zero)
// keeps the block busy while the entries above it are moved up and the code
// is then placed. After the last code of a batch the middle half of the RAM
// is read back one entry per cycle, each entry goes through the reciprocal
// multiplier, and the sum is presented.
// The result appears on average_code_o for exactly one cycle, marked by
// result_valid_o; the receiver cannot stall it, so it must take it then.
// Reset empties the batch; the RAM keeps no reset and every entry is written
// before it is read.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_trimmed_mean_top
  import atm_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [CodeBits-1:0] sample_code_i,
  output logic                     result_valid_o,
  output logic      [AvgBits-1:0]  average_code_o
);

  typedef enum logic [2:0] {
    StIdle,
    StCmp,
    StKey,
    StSum,
    StDrain
  } state_e;

  state_e                state_q, state_d;
  logic [IdxW-1:0]       fill_q, fill_d;
  logic [IdxW-1:0]       slot_q, slot_d;
  logic [IdxW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [SampleBits-1:0] key_q, key_d;
  logic [AvgBits-1:0]    acc_q, acc_d;
  logic [AvgBits-1:0]    avg_q, avg_d;
  logic                  res_vld_q, res_vld_d;
  logic                  rd_vld_q;

  logic                  accept;
  logic                  ram_we;
  logic [IdxW-1:0]       ram_waddr;
  logic [SampleBits-1:0] ram_wdata;
  logic [IdxW-1:0]       ram_raddr;
  logic [SampleBits-1:0] ram_rdata;
  logic                  rd_issue;
  logic                  finish;
  logic                  quot_vld;
  logic [SampleBits-1:0] quot;

  assign accept = start && !busy;

  atm_ram #(
    .Width (SampleBits),
    .Depth (SampleCount)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  atm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (rd_vld_q),
    .dividend_i (ram_rdata),
    .valid_o    (quot_vld),
    .quotient_o (quot)
  );

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    slot_d    = slot_q;
    rd_ptr_d  = rd_ptr_q;
    key_d     = key_q;
    acc_d     = acc_q;
    avg_d     = avg_q;
    res_vld_d = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = slot_q;
    ram_wdata = key_q;
    ram_raddr = slot_q - IdxW'(1);
    rd_issue  = 1'b0;
    finish    = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          key_d = sample_code_i[SampleBits-1:0];
          if (fill_q == '0) begin
            // An empty batch needs no search: the code goes straight in.
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = sample_code_i[SampleBits-1:0];
            fill_d    = IdxW'(1);
          end else begin
            ram_raddr = fill_q - IdxW'(1);
            slot_d    = fill_q;
            state_d   = StCmp;
          end
        end
      end
      StCmp: begin
        // The read data is the entry just below the free slot.
        ram_we    = 1'b1;
        ram_waddr = slot_q;
        if (ram_rdata > key_q) begin
          ram_wdata = ram_rdata;
          slot_d    = slot_q - IdxW'(1);
          if (slot_q == IdxW'(1)) begin
            state_d = StKey;
          end else begin
            ram_raddr = slot_q - IdxW'(2);
          end
        end else begin
          ram_wdata = key_q;
          finish    = 1'b1;
        end
      end
      StKey: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = key_q;
        finish    = 1'b1;
      end
      StSum: begin
        ram_raddr = rd_ptr_q;
        rd_issue  = 1'b1;
        rd_ptr_d  = rd_ptr_q + IdxW'(1);
        if (rd_ptr_q == SumLast) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (!rd_vld_q && !quot_vld) begin
          res_vld_d = 1'b1;
          avg_d     = acc_q;
          state_d   = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (finish) begin
      if (fill_q == LastIdx) begin
        fill_d   = '0;
        rd_ptr_d = SumFirst;
        acc_d    = '0;
        state_d  = StSum;
      end else begin
        fill_d  = fill_q + IdxW'(1);
        state_d = StIdle;
      end
    end

    // The sum wraps at the accumulator width.
    if (quot_vld) begin
      acc_d = acc_q + AvgBits'(quot);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      fill_q    <= '0;
      rd_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      rd_vld_q  <= rd_issue;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q   <= slot_d;
    rd_ptr_q <= rd_ptr_d;
    key_q    <= key_d;
    acc_q    <= acc_d;
    avg_q    <= avg_d;
  end

  assign busy           = (state_q != StIdle);
  assign result_valid_o = res_vld_q;
  assign average_code_o = avg_q;

endmodule

`default_nettype wire

// File: hw/rtl/atm_checker.sv
// ----------------------------------------------------------------------------
// atm_checker
// Port-level checks of the trimmed mean filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module atm_checker
  import atm_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               result_valid_o,
  input wire logic [AvgBits-1:0] average_code_o
);

  // A result is a single-cycle strobe.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  // A result is presented as the block returns to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result presented while the block is busy");

  // Every result follows a stretch of work on the final transaction of a batch.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result without preceding work");

  // The block only becomes busy because a transaction was taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted transaction");

  // A presented average carries a fully known value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !$isunknown(average_code_o))
    else $error("average presented with unknown bits");

endmodule

bind adc_trimmed_mean_top atm_checker u_atm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .average_code_o (average_code_o)
);

`default_nettype wire
